### src/dode_pkg.sv
// Package: shared constants, types and helpers of the delta-of-delta encoder.
package dode_pkg;

  // Widest burst one item can cause: nine code bytes plus one flush byte.
  localparam int MaxResults = 10;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int PackW      = 8 * MaxResults;

  // Coded word: left-aligned prefix, sign and magnitude, widest case 69 bits.
  localparam int WordW = 69;
  localparam int LenW  = 7;
  localparam int PendW = 7;

  // Width codes of the configuration register.
  localparam logic [1:0] WIDTH_1B = 2'd0;
  localparam logic [1:0] WIDTH_2B = 2'd1;
  localparam logic [1:0] WIDTH_4B = 2'd2;
  localparam logic [1:0] WIDTH_8B = 2'd3;
  localparam logic [1:0] WIDTH_RESET = WIDTH_8B;

  // Class limits on |dd|-1: positive side, then negative side.
  localparam logic [63:0] LIM_C0_POS = 64'd63;
  localparam logic [63:0] LIM_C0_NEG = 64'd62;
  localparam logic [63:0] LIM_C1_POS = 64'd255;
  localparam logic [63:0] LIM_C1_NEG = 64'd254;
  localparam logic [63:0] LIM_C2_POS = 64'd2047;
  localparam logic [63:0] LIM_C2_NEG = 64'd2046;
  localparam logic [63:0] LIM_C3_POS = 64'd2147483646;
  localparam logic [63:0] LIM_C3_NEG = 64'd2147483647;

  // Code lengths in bits.
  localparam logic [LenW-1:0] LEN_ZERO = 7'd1;
  localparam logic [LenW-1:0] LEN_C0   = 7'd9;
  localparam logic [LenW-1:0] LEN_C1   = 7'd12;
  localparam logic [LenW-1:0] LEN_C2   = 7'd16;
  localparam logic [LenW-1:0] LEN_C3   = 7'd37;
  localparam logic [LenW-1:0] LEN_C4   = 7'd69;

  // Position of an item within its block.
  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_SECOND,
    KIND_DD
  } kind_t;

  function automatic logic [63:0] width_mask(input logic [1:0] wc);
    logic [63:0] m;
    unique case (wc)
      WIDTH_1B: m = 64'h0000_0000_0000_00FF;
      WIDTH_2B: m = 64'h0000_0000_0000_FFFF;
      WIDTH_4B: m = 64'h0000_0000_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic sign_of(input logic [63:0] v, input logic [1:0] wc);
    logic s;
    unique case (wc)
      WIDTH_1B: s = v[7];
      WIDTH_2B: s = v[15];
      WIDTH_4B: s = v[31];
      default:  s = v[63];
    endcase
    return s;
  endfunction

  function automatic logic [CntW-1:0] raw_bytes(input logic [1:0] wc);
    logic [CntW-1:0] n;
    unique case (wc)
      WIDTH_1B: n = CntW'(1);
      WIDTH_2B: n = CntW'(2);
      WIDTH_4B: n = CntW'(4);
      default:  n = CntW'(8);
    endcase
    return n;
  endfunction

endpackage

### src/delta_of_delta_encoder_core.sv
// Top level: delta-of-delta timestamp encoder, one value in, a burst of bytes out.
//
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  input    | in_valid, in_stall, in_sample_value,         | into block
//           | in_final_sample                              |
//  result   | out_valid, out_stall, out_byte, out_run_end, | out of block
//           | out_stream_end                               |
//  config   | cfg_we, cfg_wdata (element width code)       | into block
//
// One byte leaves per cycle while out_stall is low. An item produces 1, 2, 4 or
// 8 bytes for the raw first value and raw first delta, 0 to 10 for a coded item
// (an item that yields no byte still passes through the last stage). The output
// byte buffer sets the sustained rate. From transfer in to first byte out an item
// passes through the stages in order: input register, delta-of-delta register,
// code register, byte buffer.
// Reset is synchronous and active low; it empties every stage and sets the
// width to 8 bytes. A stall on the output holds the buffer and backs up the
// stages one by one; the input stalls only once the input register cannot
// advance.
module delta_of_delta_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_sample_value,
  input  logic        in_final_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_end,
  output logic        out_stream_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);
  import dode_pkg::*;

  // Configuration and block-position state.
  logic [1:0]  wc_r;
  logic [1:0]  items_r, items_nxt;
  logic [63:0] prev_value_r, prev_value_nxt;
  logic [63:0] prev_delta_r, prev_delta_nxt;

  // Stage 1: masked delta (or raw first value).
  logic        s1_v_r;
  kind_t       s1_kind_r, s1_kind_nxt;
  logic        s1_fin_r;
  logic [63:0] s1_val_r, s1_val_nxt;

  // Stage 2: delta-of-delta (or raw value).
  logic        s2_v_r;
  kind_t       s2_kind_r;
  logic        s2_fin_r;
  logic [63:0] s2_val_r, s2_val_nxt;

  // Stage 3: left-aligned code word.
  logic             s3_v_r;
  logic             s3_raw_r, s3_raw_nxt;
  logic             s3_fin_r;
  logic [WordW-1:0] s3_word_r, s3_word_nxt;
  logic [LenW-1:0]  s3_len_r, s3_len_nxt;

  // Bit packer and output byte buffer.
  logic [PendW-1:0] pend_bits_r, pend_bits_nxt;
  logic [2:0]       pend_cnt_r, pend_cnt_nxt;
  logic [7:0]       ob_r [MaxResults];
  logic [7:0]       ob_nxt [MaxResults];
  logic [CntW-1:0]  ob_left_r, ob_left_nxt;
  logic             ob_fin_r, ob_fin_nxt;

  // Handshake and flow control.
  logic in_xfer, out_xfer, load_ok;
  logic s1_go, s1_free, s2_go, s2_free, s3_go, s3_free;

  logic [63:0] mask;
  logic [63:0] cur;

  assign mask     = width_mask(wc_r);
  assign out_valid = (ob_left_r != '0);
  assign out_xfer  = out_valid && !out_stall;
  // The buffer takes a new burst once empty or while its last byte transfers.
  assign load_ok   = (ob_left_r == '0) || ((ob_left_r == CntW'(1)) && !out_stall);

  assign s3_go   = s3_v_r && load_ok;
  assign s3_free = !s3_v_r || load_ok;
  assign s2_go   = s2_v_r && s3_free;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_go   = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s2_free;

  assign in_stall = !s1_free;
  assign in_xfer  = in_valid && !in_stall;

  assign out_byte       = ob_r[0];
  assign out_run_end    = (ob_left_r == CntW'(1));
  assign out_stream_end = (ob_left_r == CntW'(1)) && ob_fin_r;

  // Accept side: block position and delta against the previous accepted value.
  assign cur = in_sample_value & mask;

  always_comb begin
    unique case (items_r)
      2'd0:    s1_kind_nxt = KIND_FIRST;
      2'd1:    s1_kind_nxt = KIND_SECOND;
      default: s1_kind_nxt = KIND_DD;
    endcase
    s1_val_nxt = (s1_kind_nxt == KIND_FIRST) ? cur : ((cur - prev_value_r) & mask);
    if (in_final_sample) begin
      items_nxt      = 2'd0;
      prev_value_nxt = '0;
    end else begin
      items_nxt      = (items_r == 2'd2) ? 2'd2 : items_r + 2'd1;
      prev_value_nxt = cur;
    end
  end

  // Stage 2: subtract the previous delta; the first or final item of a block zeroes it.
  always_comb begin
    s2_val_nxt = (s1_kind_r == KIND_DD) ? ((s1_val_r - prev_delta_r) & mask) : s1_val_r;
    prev_delta_nxt = (s1_fin_r || (s1_kind_r == KIND_FIRST)) ? '0 : s1_val_r;
  end

  // Stage 3: classify |dd|-1 and build the left-aligned code word.
  always_comb begin
    logic        neg;
    logic [63:0] magm1;
    neg   = sign_of(s2_val_r, wc_r);
    // For a negative dd, |dd|-1 equals the masked complement.
    magm1 = neg ? (~s2_val_r & mask) : (s2_val_r - 64'd1);
    s3_raw_nxt = (s2_kind_r != KIND_DD);
    if (s3_raw_nxt) begin
      s3_word_nxt = {5'b0, s2_val_r};
      s3_len_nxt  = '0;
    end else if (s2_val_r == '0) begin
      s3_word_nxt = '0;
      s3_len_nxt  = LEN_ZERO;
    end else if (magm1 < (neg ? LIM_C0_NEG : LIM_C0_POS)) begin
      s3_word_nxt = {2'b10, neg, magm1[5:0], 60'b0};
      s3_len_nxt  = LEN_C0;
    end else if (magm1 < (neg ? LIM_C1_NEG : LIM_C1_POS)) begin
      s3_word_nxt = {3'b110, neg, magm1[7:0], 57'b0};
      s3_len_nxt  = LEN_C1;
    end else if (magm1 < (neg ? LIM_C2_NEG : LIM_C2_POS)) begin
      s3_word_nxt = {4'b1110, neg, magm1[10:0], 53'b0};
      s3_len_nxt  = LEN_C2;
    end else if (magm1 < (neg ? LIM_C3_NEG : LIM_C3_POS)) begin
      s3_word_nxt = {5'b11110, neg, magm1[30:0], 32'b0};
      s3_len_nxt  = LEN_C3;
    end else begin
      s3_word_nxt = {5'b11111, neg, magm1[62:0]};
      s3_len_nxt  = LEN_C4;
    end
  end

  // Packer: splice the code behind the pending bits and cut whole bytes.
  always_comb begin
    logic [PendW-1:0] pend_left;
    logic [PackW-1:0] packed_bits;
    logic [LenW-1:0]  total;
    logic [3:0]       nfull;
    logic [2:0]       rem;
    logic [7:0]       cb [MaxResults];
    logic [CntW-1:0]  ld_cnt;
    pend_left   = PendW'(pend_bits_r << (3'd7 - pend_cnt_r));
    packed_bits = {pend_left, {(PackW - PendW){1'b0}}}
                | ({s3_word_r, {(PackW - WordW){1'b0}}} >> pend_cnt_r);
    total = LenW'(pend_cnt_r) + s3_len_r;
    nfull = total[6:3];
    rem   = total[2:0];
    for (int i = 0; i < MaxResults; i++) begin
      cb[i] = packed_bits[PackW - 1 - 8 * i -: 8];
    end

    ob_nxt        = ob_r;
    ob_left_nxt   = ob_left_r;
    ob_fin_nxt    = ob_fin_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    ld_cnt        = '0;

    // Advance the buffer on each transfer.
    if (out_xfer) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        ob_nxt[i] = ob_r[i + 1];
      end
      ob_left_nxt = ob_left_r - CntW'(1);
    end

    if (s3_go) begin
      if (s3_raw_r) begin
        // Raw value, little-endian; no pending bits exist at this point.
        for (int i = 0; i < MaxResults; i++) begin
          ob_nxt[i] = (i < 8) ? s3_word_r[8 * (i % 8) +: 8] : 8'h00;
        end
        ld_cnt = raw_bytes(wc_r);
      end else begin
        for (int i = 0; i < MaxResults; i++) begin
          ob_nxt[i] = cb[i];
        end
        // Flush the partial byte, already zero padded, at block end.
        ld_cnt = CntW'(nfull) + CntW'(s3_fin_r && (rem != 3'd0));
        pend_bits_nxt = PendW'(cb[nfull] >> (4'd8 - {1'b0, rem}));
        pend_cnt_nxt  = rem;
      end
      if (s3_fin_r) begin
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
      end
      ob_left_nxt = ld_cnt;
      ob_fin_nxt  = s3_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r         <= WIDTH_RESET;
      items_r      <= 2'd0;
      prev_value_r <= '0;
      prev_delta_r <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      pend_bits_r  <= '0;
      pend_cnt_r   <= '0;
      ob_left_r    <= '0;
    end else begin
      if (cfg_we) begin
        wc_r <= cfg_wdata;
      end
      if (in_xfer) begin
        items_r      <= items_nxt;
        prev_value_r <= prev_value_nxt;
      end
      if (s1_go) begin
        prev_delta_r <= prev_delta_nxt;
      end
      if (s1_free) begin
        s1_v_r <= in_xfer;
      end
      if (s2_free) begin
        s2_v_r <= s1_go;
      end
      if (s3_free) begin
        s3_v_r <= s2_go;
      end
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      ob_left_r   <= ob_left_nxt;
    end
  end

  // Payload registers: load on advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= s1_kind_nxt;
      s1_fin_r  <= in_final_sample;
      s1_val_r  <= s1_val_nxt;
    end
    if (s1_go) begin
      s2_kind_r <= s1_kind_r;
      s2_fin_r  <= s1_fin_r;
      s2_val_r  <= s2_val_nxt;
    end
    if (s2_go) begin
      s3_raw_r  <= s3_raw_nxt;
      s3_fin_r  <= s2_fin_r;
      s3_word_r <= s3_word_nxt;
      s3_len_r  <= s3_len_nxt;
    end
    ob_r     <= ob_nxt;
    ob_fin_r <= ob_fin_nxt;
  end

endmodule

### src/dode_checker.sv
// Checker: port-level properties of the encoder, bound to the top level.
module dode_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_end,
  input logic       out_stream_end
);
  import dode_pkg::*;

  // Bytes transferred since the last run end.
  logic [CntW-1:0] run_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (out_valid && !out_stall) begin
      run_cnt_r <= out_run_end ? '0 : run_cnt_r + CntW'(1);
    end
  end

  // Reset empties the block: no result and no input stall on the next cycle.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // A block end always closes the item's run.
  a_stream_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_run_end)
    else $error("stream end without run end");

  // No item produces more than the widest burst.
  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> run_cnt_r < CntW'(MaxResults))
    else $error("run longer than the widest burst");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_run_end)
      && $stable(out_stream_end))
    else $error("stalled result changed");

endmodule

bind delta_of_delta_encoder_core dode_checker u_dode_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_run_end    (out_run_end),
  .out_stream_end (out_stream_end)
);

### tb/tb_delta_of_delta_encoder_core.sv
// Testbench for the delta-of-delta encoder core, checked byte by byte against its own predictor.
`timescale 1ns / 1ps

module tb_delta_of_delta_encoder_core;
  import dode_pkg::*;

  // Cycles to let a zero-byte item clear the four stages before the block is idle.
  localparam int DRAIN_CYCLES = 16;
  // Generous ceiling on the whole run, reckoned from long stalls on every byte.
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int NUM_EDGES    = 19;

  // Unary prefixes, right-aligned.
  localparam logic [4:0] PFX_C0 = 5'b00010;
  localparam logic [4:0] PFX_C1 = 5'b00110;
  localparam logic [4:0] PFX_C2 = 5'b01110;
  localparam logic [4:0] PFX_C3 = 5'b11110;
  localparam logic [4:0] PFX_C4 = 5'b11111;

  // Delta-of-delta values on both sides of every class boundary, plus the extremes
  // of the 64-bit range (the last one is the most negative value).
  localparam logic [63:0] DD_EDGES [NUM_EDGES] = '{
    64'd0, 64'd63, -64'd62, 64'd64, -64'd63, 64'd255, -64'd254, 64'd256, -64'd255,
    64'd2047, -64'd2046, 64'd2048, -64'd2047,
    64'd2147483646, -64'd2147483647, 64'd2147483647, -64'd2147483648,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000
  };

  typedef struct {
    logic [63:0] value;
    logic        fin;
  } sample_item_t;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } coded_byte_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [63:0] in_sample_value = '0;
  logic        in_final_sample = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [7:0]  out_byte;
  logic        out_run_end;
  logic        out_stream_end;
  logic        cfg_we          = 1'b0;
  logic [1:0]  cfg_wdata       = WIDTH_8B;

  delta_of_delta_encoder_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_value(in_sample_value),
    .in_final_sample(in_final_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Samples waiting for the driver, and the bytes the encoder owes us.
  sample_item_t sample_q[$];
  coded_byte_t  expected_bytes[$];

  int unsigned queued_samples   = 0;
  int unsigned accepted_samples = 0;
  int unsigned error_count      = 0;
  int unsigned cycle_count      = 0;
  logic        in_fire          = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the width register and of the encoder state.
  // ---------------------------------------------------------------------------
  logic [1:0]  width_sel   = WIDTH_8B;
  kind_t       block_pos   = KIND_FIRST;
  logic [63:0] last_sample = '0;
  logic [63:0] last_delta  = '0;
  logic [6:0]  pend_bits   = '0;
  logic [2:0]  pend_cnt    = '0;

  function automatic logic [63:0] elem_mask(input logic [1:0] wc);
    case (wc)
      WIDTH_1B: return 64'h0000_0000_0000_00FF;
      WIDTH_2B: return 64'h0000_0000_0000_FFFF;
      WIDTH_4B: return 64'h0000_0000_FFFF_FFFF;
      default:  return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  function automatic void emit_octet(input logic [7:0] b);
    coded_byte_t e;
    e.data       = b;
    e.run_end    = 1'b0;
    e.stream_end = 1'b0;
    expected_bytes.push_back(e);
  endfunction

  // Shift the low n bits of v into the pending byte, MSB first; emit each full byte.
  function automatic void append_bits(input int n, input logic [63:0] v);
    logic [7:0] acc;
    for (int i = n; i > 0; i--) begin
      acc = {pend_bits, v[i-1]};
      if (pend_cnt == 3'd7) begin
        emit_octet(acc);
        pend_bits = '0;
        pend_cnt  = '0;
      end else begin
        pend_bits = acc[6:0];
        pend_cnt  = pend_cnt + 3'd1;
      end
    end
  endfunction

  function automatic void code_delta_of_delta(input logic [63:0] dd, input logic [63:0] m,
                                              input int wbits);
    logic        neg;
    logic [63:0] mag;
    int          pre_len;
    logic [4:0]  prefix;
    int          mag_len;
    if (dd == '0) begin
      append_bits(1, 64'd0);
      return;
    end
    neg = dd[wbits-1];
    // The most negative value keeps its unsigned magnitude, 2^(w-1).
    mag = neg ? ((~dd + 64'd1) & m) : dd;
    if (mag <= (neg ? 64'd62 : 64'd63)) begin
      pre_len = 2; prefix = PFX_C0; mag_len = 6;
    end else if (mag <= (neg ? 64'd254 : 64'd255)) begin
      pre_len = 3; prefix = PFX_C1; mag_len = 8;
    end else if (mag <= (neg ? 64'd2046 : 64'd2047)) begin
      pre_len = 4; prefix = PFX_C2; mag_len = 11;
    end else if (mag <= (neg ? 64'd2147483647 : 64'd2147483646)) begin
      pre_len = 5; prefix = PFX_C3; mag_len = 31;
    end else begin
      pre_len = 5; prefix = PFX_C4; mag_len = 63;
    end
    append_bits(pre_len, 64'(prefix));
    append_bits(1, 64'(neg));
    append_bits(mag_len, mag - 64'd1);
  endfunction

  // Work out every byte one accepted sample produces and queue it.
  function automatic void encode_sample(input logic [63:0] sample, input logic fin);
    logic [63:0] m;
    logic [63:0] cur;
    logic [63:0] d;
    logic [63:0] dd;
    int          nbytes;
    int          first;
    nbytes = 1 << width_sel;
    m      = elem_mask(width_sel);
    cur    = sample & m;
    first  = expected_bytes.size();
    case (block_pos)
      KIND_FIRST: begin
        for (int i = 0; i < nbytes; i++) emit_octet(cur[8*i +: 8]);
        last_delta = '0;
        block_pos  = KIND_SECOND;
      end
      KIND_SECOND: begin
        d = (cur - last_sample) & m;
        for (int i = 0; i < nbytes; i++) emit_octet(d[8*i +: 8]);
        last_delta = d;
        block_pos  = KIND_DD;
      end
      default: begin
        // Stored values may come from a wider setting: reduce them here.
        d  = (cur - last_sample) & m;
        dd = (d - last_delta) & m;
        last_delta = d;
        code_delta_of_delta(dd, m, 8 * nbytes);
      end
    endcase
    last_sample = cur;
    if (fin) begin
      // Flush the partial byte left-aligned, zero padded, then start a new block.
      if (pend_cnt != '0) emit_octet(8'({1'b0, pend_bits} << (4'd8 - 4'(pend_cnt))));
      block_pos   = KIND_FIRST;
      last_sample = '0;
      last_delta  = '0;
      pend_bits   = '0;
      pend_cnt    = '0;
    end
    if (expected_bytes.size() > first) begin
      expected_bytes[expected_bytes.size()-1].run_end    = 1'b1;
      expected_bytes[expected_bytes.size()-1].stream_end = fin;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    coded_byte_t e;
    cycle_count++;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      // Writes only land while the encoder is idle, so apply them before any sample.
      if (cfg_we) width_sel = cfg_wdata;
      if (in_fire) begin
        encode_sample(in_sample_value, in_final_sample);
        accepted_samples++;
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: unexpected transfer, actual %02h", out_byte);
          error_count++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.data) begin
            $error("out_byte: expected %02h, actual %02h", e.data, out_byte);
            error_count++;
          end
          if (out_run_end !== e.run_end) begin
            $error("out_run_end: expected %0b, actual %0b", e.run_end, out_run_end);
            error_count++;
          end
          if (out_stream_end !== e.stream_end) begin
            $error("out_stream_end: expected %0b, actual %0b", e.stream_end, out_stream_end);
            error_count++;
          end
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Idle patterns: mostly short gaps, a few long ones, and calm stretches.
  // ---------------------------------------------------------------------------
  int unsigned in_gap_left    = 0;
  int unsigned in_calm_left   = 0;
  int unsigned stall_left     = 0;
  int unsigned out_calm_left  = 0;

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int unsigned next_gap();
    if (in_calm_left > 0) begin
      in_calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      in_calm_left = $urandom_range(10, 30);
      return 0;
    end
    return ($urandom_range(0, 99) < 50) ? 0 : idle_length();
  endfunction

  // Driver: change inputs at the falling edge; hold the payload while stalled.
  always @(negedge clk) begin
    sample_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        nxt = sample_q.pop_front();
        in_valid        <= 1'b1;
        in_sample_value <= nxt.value;
        in_final_sample <= nxt.fin;
        in_gap_left = next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (out_calm_left > 0) begin
      out_calm_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 39) == 0) begin
      out_calm_left = $urandom_range(20, 60);
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 35) begin
      out_stall <= 1'b1;
      stall_left = idle_length() - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation: build well-formed sample runs from chosen deltas-of-delta.
  // ---------------------------------------------------------------------------
  logic [1:0]  gen_width = WIDTH_8B;
  kind_t       gen_pos   = KIND_FIRST;
  logic [63:0] gen_prev  = '0;
  logic [63:0] gen_delta = '0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Queue one sample; scramble the bits above the element width, which must be ignored.
  function automatic void push_next(input logic [63:0] value, input logic fin);
    sample_item_t it;
    it.value = value ^ (rand64() & ~elem_mask(gen_width));
    it.fin   = fin;
    sample_q.push_back(it);
    queued_samples++;
    gen_delta = (gen_pos == KIND_FIRST) ? 64'd0 : value - gen_prev;
    gen_prev  = value;
    gen_pos   = fin ? KIND_FIRST : ((gen_pos == KIND_FIRST) ? KIND_SECOND : KIND_DD);
  endfunction

  function automatic void push_dd(input logic [63:0] dd, input logic fin);
    push_next(gen_prev + gen_delta + dd, fin);
  endfunction

  function automatic logic [63:0] pick_dd();
    int unsigned r;
    logic [63:0] mag;
    r = $urandom_range(0, 99);
    if (r < 35) return '0;
    if (r < 60) mag = 64'($urandom_range(1, 64));
    else if (r < 72) mag = 64'($urandom_range(60, 300));
    else if (r < 82) mag = 64'($urandom_range(250, 2100));
    else if (r < 90) mag = {31'd0, 1'($urandom_range(0, 1)), $urandom};
    else if (r < 95) return DD_EDGES[$urandom_range(0, NUM_EDGES - 1)];
    else return rand64();
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Wait until every sample is taken and every byte is back, then let stragglers clear.
  task automatic wait_drained();
    @(negedge clk);
    while (accepted_samples != queued_samples || expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_width(input logic [1:0] wc);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= wc;
    gen_width = wc;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [1:0]  wc;
    logic [1:0]  sweep [4];
    logic        fin;
    int unsigned n;
    int unsigned total;
    int unsigned phase;
    sweep = '{WIDTH_1B, WIDTH_2B, WIDTH_4B, WIDTH_8B};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Full width: raw first value near the top so later values wrap past zero,
    // then every class boundary, the 64-bit extremes, and a flush.
    set_width(WIDTH_8B);
    push_next(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    push_dd(64'd10, 1'b0);
    for (int i = 0; i < NUM_EDGES; i++) push_dd(DD_EDGES[i], i == NUM_EDGES - 1);

    // Narrowest width: a block that ends on its first sample, then the most
    // negative byte-wide delta-of-delta at block end.
    set_width(WIDTH_1B);
    push_next(64'd0, 1'b1);
    push_next(64'hFF, 1'b0);
    push_dd(64'd5, 1'b0);
    push_dd(64'h80, 1'b1);

    // Random phases. Each width change waits for the encoder to go idle, which also
    // holds the sender off until every byte is back. A phase that ends without a
    // final sample carries its block over into the next width.
    total = queued_samples;
    phase = 0;
    while (total < 90) begin
      wc = (phase < 4) ? sweep[phase] : 2'($urandom_range(0, 3));
      set_width(wc);
      n = $urandom_range(12, 25);
      for (int k = 0; k < n; k++) begin
        fin = (k == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
        if (gen_pos == KIND_FIRST || $urandom_range(0, 99) < 8) push_next(rand64(), fin);
        else push_dd(pick_dd(), fin);
      end
      total += n;
      phase++;
    end

    wait_drained();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
src/dode_pkg.sv
src/delta_of_delta_encoder_core.sv
src/dode_checker.sv
tb/tb_delta_of_delta_encoder_core.sv
